// File: rtl/i2c_ram_pkg.sv
// Package for the I2C register access master: sequencer states, tick
// payload and result structs. No dependencies.
`default_nettype none
package i2c_ram_pkg;
   localparam int MaxBurst = 8;
   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_BURST = 2'd3;
   localparam logic [1:0] CSR_ADDR  = 2'd0;
   localparam logic [1:0] CSR_START = 2'd1;
   localparam logic [1:0] CSR_LEN   = 2'd2;
   localparam logic [1:0] CSR_TICKS = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SA, ST_SB, ST_SC, ST_RS, ST_TXL, ST_TXH, ST_TAL,
      ST_TAH, ST_RXL, ST_RXH, ST_MAL, ST_MAH, ST_PA, ST_PB, ST_PC
   } seq_state_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] register_address;
      logic [7:0] write_data;
      logic       sda_in;
   } tick_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_pull_low;
      logic       busy_res;
      logic       byte_valid;
      logic [7:0] read_byte;
      logic [2:0] byte_index;
      logic       last_byte;
      logic       ack_error;
      logic       done_res;
   } result_type;
endpackage
`default_nettype wire

// File: rtl/i2c_ram_front.sv
// Front end: a two-entry queue towards the sequencer.
// Depends on i2c_ram_pkg.
`default_nettype none
module i2c_ram_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_stall,
   input  i2c_ram_pkg::tick_type in_tick,
   output logic                  q_valid,
   input  wire                   q_take,
   output i2c_ram_pkg::tick_type q_tick
);
   import i2c_ram_pkg::*;
   tick_type   mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_stall = (cnt_ff == 2'd2);
   assign push = in_valid && !in_stall;
   assign pop = q_take && q_valid;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_tick = mem_ff[rp_ff];

   always_comb begin
      wp_in = wp_ff ^ push;
      rp_in = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= in_tick;
   end

`ifndef SYNTH
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !pop) else $error("pop from empty queue");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count overflow");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 && !pop |=> cnt_ff == 2'd2) else $error("full queue lost entry");
`endif
endmodule
`default_nettype wire

// File: rtl/i2c_ram_seq.sv
// Back end: bus sequencer that turns one tick into line drive and status,
// with a result register and skid stage. Depends on i2c_ram_pkg.
`default_nettype none
module i2c_ram_seq (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     q_valid,
   output logic                    q_take,
   input  i2c_ram_pkg::tick_type   q_tick,
   input  wire  [6:0]              dev_addr,
   input  wire  [7:0]              burst_reg,
   input  wire  [3:0]              burst_len,
   input  wire  [7:0]              ticks,
   output logic                    out_valid,
   input  wire                     out_stall,
   output i2c_ram_pkg::result_type out_res
);
   import i2c_ram_pkg::*;
   seq_state_type st_ff, st_in;
   logic [7:0] ph_ff, ph_in, sh_ff, sh_in, reg_ff, reg_in, dat_ff, dat_in;
   logic [3:0] bit_ff, bit_in, byc_ff, byc_in;
   logic [1:0] cmd_ff, cmd_in;
   logic       nack_ff, nack_in;
   result_type res, ov_ff, sk_ff;
   logic       ov_v_ff, sk_v_ff;
   logic [7:0] eticks, ph_inc;
   logic [3:0] elen;
   logic       last, step, wrap;
   seq_state_type cur;

   assign q_take = !sk_v_ff;
   assign step = q_valid && q_take;
   assign eticks = (ticks == 8'd0) ? 8'd1 : ticks;

   function automatic logic [7:0] tx_byte(input logic [3:0] k, input logic [1:0] c,
         input logic [6:0] a, input logic [7:0] br, input logic [7:0] lr,
         input logic [7:0] ld);
      case (k)
         4'd0: tx_byte = {a, 1'b0};
         4'd1: tx_byte = (c == CMD_BURST) ? br : lr;
         4'd2: tx_byte = ld;
         default: tx_byte = {a, 1'b1};
      endcase
   endfunction

   // next-state and datapath
   always_comb begin
      st_in = st_ff; ph_in = ph_ff; sh_in = sh_ff; reg_in = reg_ff;
      dat_in = dat_ff; bit_in = bit_ff; byc_in = byc_ff; cmd_in = cmd_ff;
      nack_in = nack_ff;
      cur = st_ff;
      if (st_ff == ST_IDLE && q_tick.command != CMD_NONE) begin
         cmd_in = q_tick.command; reg_in = q_tick.register_address;
         dat_in = q_tick.write_data; cur = ST_SA; ph_in = 8'd0;
         bit_in = 4'd0; byc_in = 4'd0; sh_in = 8'd0; nack_in = 1'b0;
      end
      // last uses pre-latch values, as the byte count is zero once a command lands
      elen = (cmd_ff != CMD_BURST) ? 4'd1 :
             (burst_len == 4'd0) ? 4'd1 :
             (burst_len > 4'(MaxBurst)) ? 4'(MaxBurst) : burst_len;
      last = ({1'b0, byc_ff} + 5'd1) >= {1'b0, elen};
      st_in = cur;
      ph_inc = ph_in + 8'd1;
      wrap = ph_inc >= eticks;
      if (cur != ST_IDLE) begin
         ph_in = wrap ? 8'd0 : ph_inc;
         if (wrap) begin
            unique case (cur)
               ST_SA: st_in = ST_SB;
               ST_SB: st_in = ST_SC;
               ST_RS: st_in = ST_SA;
               ST_SC: begin
                  sh_in = tx_byte(byc_in, cmd_in, dev_addr, burst_reg, reg_in, dat_in);
                  bit_in = 4'd0; st_in = ST_TXL;
               end
               ST_TXL: st_in = ST_TXH;
               ST_TXH: begin
                  sh_in = {sh_in[6:0], 1'b0};
                  bit_in = bit_in + 4'd1;
                  st_in = (bit_in >= 4'd8) ? ST_TAL : ST_TXL;
               end
               ST_TAL: st_in = ST_TAH;
               ST_TAH: begin
                  nack_in = nack_in | q_tick.sda_in;
                  if (cmd_in == CMD_WRITE) begin
                     if (byc_in >= 4'd2) st_in = ST_PA;
                     else begin
                        byc_in = byc_in + 4'd1;
                        sh_in = tx_byte(byc_in, cmd_in, dev_addr, burst_reg, reg_in, dat_in);
                        bit_in = 4'd0; st_in = ST_TXL;
                     end
                  end else if (byc_in == 4'd0) begin
                     byc_in = 4'd1;
                     sh_in = tx_byte(4'd1, cmd_in, dev_addr, burst_reg, reg_in, dat_in);
                     bit_in = 4'd0; st_in = ST_TXL;
                  end else if (byc_in == 4'd1) begin
                     byc_in = 4'd3; st_in = ST_RS;
                  end else begin
                     byc_in = 4'd0; bit_in = 4'd0; sh_in = 8'd0; st_in = ST_RXL;
                  end
               end
               ST_RXL: st_in = ST_RXH;
               ST_RXH: begin
                  sh_in = {sh_in[6:0], q_tick.sda_in};
                  bit_in = bit_in + 4'd1;
                  st_in = (bit_in >= 4'd8) ? ST_MAL : ST_RXL;
               end
               ST_MAL: st_in = ST_MAH;
               ST_MAH: begin
                  if (last) st_in = ST_PA;
                  else begin
                     byc_in = byc_in + 4'd1; bit_in = 4'd0; sh_in = 8'd0;
                     st_in = ST_RXL;
                  end
               end
               ST_PA: st_in = ST_PB;
               ST_PB: st_in = ST_PC;
               ST_PC: st_in = ST_IDLE;
               default: st_in = ST_IDLE;
            endcase
         end
      end
   end

   // outputs of the tick
   always_comb begin
      res = '0;
      res.scl_level = 1'b1;
      res.busy_res = 1'b1;
      unique case (cur)
         ST_IDLE: res.busy_res = 1'b0;
         ST_SA: res.sda_pull_low = 1'b0;
         ST_SB: res.sda_pull_low = 1'b1;
         ST_SC: begin res.scl_level = 1'b0; res.sda_pull_low = 1'b1; end
         ST_RS: res.scl_level = 1'b0;
         ST_TXL: begin res.scl_level = 1'b0; res.sda_pull_low = !sh_ff[7]; end
         ST_TXH: res.sda_pull_low = !sh_ff[7];
         ST_TAL, ST_RXL: res.scl_level = 1'b0;
         ST_TAH, ST_RXH: res.sda_pull_low = 1'b0;
         ST_MAL: begin res.scl_level = 1'b0; res.sda_pull_low = !last; end
         ST_MAH: res.sda_pull_low = !last;
         ST_PA: begin res.scl_level = 1'b0; res.sda_pull_low = 1'b1; end
         ST_PB: res.sda_pull_low = 1'b1;
         ST_PC: res.sda_pull_low = 1'b0;
         default: res.busy_res = 1'b0;
      endcase
      if (cur == ST_RXH && wrap && st_in == ST_MAL) begin
         res.byte_valid = 1'b1;
         res.read_byte = sh_in;
         res.byte_index = byc_in[2:0];
         res.last_byte = last;
      end
      res.ack_error = nack_in;
      res.done_res = (cur == ST_PC) && wrap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; ph_ff <= 8'd0; sh_ff <= 8'd0; reg_ff <= 8'd0;
         dat_ff <= 8'd0; bit_ff <= 4'd0; byc_ff <= 4'd0; cmd_ff <= CMD_NONE;
         nack_ff <= 1'b0; ov_v_ff <= 1'b0; sk_v_ff <= 1'b0;
      end else begin
         if (step) begin
            st_ff <= st_in; ph_ff <= ph_in; sh_ff <= sh_in; reg_ff <= reg_in;
            dat_ff <= dat_in; bit_ff <= bit_in; byc_ff <= byc_in; cmd_ff <= cmd_in;
            nack_ff <= nack_in;
         end
         if (!ov_v_ff || !out_stall) begin
            ov_v_ff <= step || sk_v_ff;
            sk_v_ff <= 1'b0;
         end else if (step) begin
            sk_v_ff <= 1'b1;
         end
      end
      if (!ov_v_ff || !out_stall) ov_ff <= sk_v_ff ? sk_ff : res;
      else if (step) sk_ff <= res;
   end

   assign out_valid = ov_v_ff;
   assign out_res = ov_ff;

`ifndef SYNTH
   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      sk_v_ff |-> ov_v_ff) else $error("skid full with empty output");
   a_no_step_skid: assert property (@(posedge clock) disable iff (reset)
      sk_v_ff |-> !step) else $error("tick taken with skid full");
   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_IDLE |-> ph_ff == 8'd0) else $error("phase count in idle");
`endif
endmodule
`default_nettype wire

// File: rtl/i2c_register_access_master.sv
// I2C register access master: one tick in, one line-drive result out.
// An accepted tick is held in a queue entry, then in the output register behind the
// combinational sequencer step; throughput one tick per cycle while the output is
// not stalled. Input stalls only once the two-entry queue is full behind a stalled output.
// Reset (synchronous, active high) empties queue and output, returns sequencer to
// idle and loads register defaults: address 83, burst start 50, length 6, ticks 5.
`default_nettype none
module i2c_register_access_master (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire  [1:0] req_command,
   input  wire  [7:0] req_register_address,
   input  wire  [7:0] req_write_data,
   input  wire        req_sda_in,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic       rsp_scl_level,
   output logic       rsp_sda_pull_low,
   output logic       rsp_busy_res,
   output logic       rsp_byte_valid,
   output logic [7:0] rsp_read_byte,
   output logic [2:0] rsp_byte_index,
   output logic       rsp_last_byte,
   output logic       rsp_ack_error,
   output logic       rsp_done_res,
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire  [1:0] csr_index,
   input  wire  [7:0] csr_data
);
   import i2c_ram_pkg::*;
   tick_type   tick, q_tick;
   result_type res;
   logic       q_valid, q_take;
   logic [6:0] addr_ff;
   logic [7:0] start_ff, ticks_ff;
   logic [3:0] len_ff;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= 7'd83; start_ff <= 8'd50; len_ff <= 4'd6; ticks_ff <= 8'd5;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ADDR:  addr_ff <= csr_data[6:0];
            CSR_START: start_ff <= csr_data;
            CSR_LEN:   len_ff <= csr_data[3:0];
            default:   ticks_ff <= csr_data;
         endcase
      end
   end

   assign tick = '{command: req_command, register_address: req_register_address,
                   write_data: req_write_data, sda_in: req_sda_in};

   i2c_ram_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_stall(req_stall),
      .in_tick(tick), .q_valid(q_valid), .q_take(q_take), .q_tick(q_tick));

   i2c_ram_seq u_seq (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_take(q_take),
      .q_tick(q_tick), .dev_addr(addr_ff), .burst_reg(start_ff), .burst_len(len_ff),
      .ticks(ticks_ff), .out_valid(rsp_valid), .out_stall(rsp_stall), .out_res(res));

   assign rsp_scl_level = res.scl_level;
   assign rsp_sda_pull_low = res.sda_pull_low;
   assign rsp_busy_res = res.busy_res;
   assign rsp_byte_valid = res.byte_valid;
   assign rsp_read_byte = res.read_byte;
   assign rsp_byte_index = res.byte_index;
   assign rsp_last_byte = res.last_byte;
   assign rsp_ack_error = res.ack_error;
   assign rsp_done_res = res.done_res;
endmodule
`default_nettype wire
